// ----- rtl/trp_pkg.sv -----
// Shared types and constants for the transmit ring packetizer.
// Holds the request and result item structs, the kind codes and default sizes.
// No dependencies.
package trp_pkg;

	// Default sizes handed to the top level
	localparam int FIFO_DEPTH_DEF = 256;
	localparam int PACKET_MAX_DEF = 64;

	// Request kind codes
	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_KICK = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	// Result kind codes
	localparam logic RES_STATUS = 1'b0;
	localparam logic RES_PACKET = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       link_configured;
	} req_t;

	typedef struct packed {
		logic       result_kind;
		logic       accepted;
		logic [7:0] packet_byte;
		logic       packet_last;
	} rsp_t;

	// Load request from the controller into the output register
	typedef struct packed {
		logic valid;
		rsp_t item;
	} load_t;

endpackage

// ----- rtl/trp_ram.sv -----
// Generic synchronous RAM: one write port, one read port, registered read.
// Read data holds its value while no read is issued.
// No dependencies.
module trp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/trp_out.sv -----
// Output register of the packetizer: one result item with its valid flag.
// Depends on trp_pkg for the result and load types.
module trp_out (
	input  logic          clk,
	input  logic          arst_n,
	input  trp_pkg::load_t load,
	output logic          free,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output trp_pkg::rsp_t rsp
);

	logic          valid_q;
	trp_pkg::rsp_t item_q;

	// Slot is free when empty or being taken at this edge
	assign free      = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp       = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load.valid) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload, no reset needed
	always_ff @(posedge clk) begin
		if (load.valid) begin
			item_q <= load.item;
		end
	end

endmodule

// ----- rtl/trp_ctrl.sv -----
// Controller of the packetizer: ring pointers, busy flag, packet drain sequencer.
// Drives the ring RAM ports and loads the output register.
// Depends on trp_pkg.
module trp_ctrl #(
	parameter int FIFO_DEPTH = trp_pkg::FIFO_DEPTH_DEF,
	parameter int PACKET_MAX = trp_pkg::PACKET_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  trp_pkg::req_t                 req,
	input  logic                          out_free,
	output trp_pkg::load_t                load,
	output logic                          wr_en,
	output logic [$clog2(FIFO_DEPTH)-1:0] wr_addr,
	output logic [7:0]                    wr_data,
	output logic                          rd_en,
	output logic [$clog2(FIFO_DEPTH)-1:0] rd_addr,
	input  logic [7:0]                    rd_data
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = (PACKET_MAX > 1) ? $clog2(PACKET_MAX) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PACKET_MAX - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]       state_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rd_valid_s1;
	logic             last_s1;

	logic             req_fire;
	logic             is_push;
	logic             is_kick;
	logic             is_done;
	logic             empty;
	logic             full;
	logic [PTR_W-1:0] wr_next;
	logic [PTR_W-1:0] rd_next;
	logic             busy_eff;
	logic             start;
	logic             s1_move;
	logic             issue_last;

	// Decode and ring status
	assign req_stall = (state_q != ST_IDLE) || !out_free;
	assign req_fire  = req_valid && !req_stall;
	assign is_push   = req.kind == trp_pkg::KIND_PUSH;
	assign is_kick   = req.kind == trp_pkg::KIND_KICK;
	assign is_done   = req.kind == trp_pkg::KIND_DONE;

	assign wr_next = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
	assign empty   = rd_ptr_q == wr_ptr_q;
	assign full    = wr_next == rd_ptr_q;

	// Transmit complete frees the endpoint before the start check
	assign busy_eff = is_done ? 1'b0 : busy_q;
	assign start    = req_fire && (is_kick || is_done) && req.link_configured
	                  && !busy_eff && !empty;

	// Ring write on an accepted push
	assign wr_en   = req_fire && is_push && req.link_configured && !full;
	assign wr_addr = wr_ptr_q;
	assign wr_data = req.data_byte;

	// Drain: issue a read only when the read stage is free or moving on
	assign s1_move    = rd_valid_s1 && out_free;
	assign rd_en      = (state_q == ST_DRAIN) && (!rd_valid_s1 || s1_move);
	assign rd_addr    = rd_ptr_q;
	assign issue_last = (rd_next == wr_ptr_q) || (cnt_q == CNT_LAST);

	// Output register load: packet bytes while draining, status on a push
	always_comb begin
		load = '0;
		if (s1_move) begin
			load.valid            = 1'b1;
			load.item.result_kind = trp_pkg::RES_PACKET;
			load.item.packet_byte = rd_data;
			load.item.packet_last = last_s1;
		end else if (req_fire && is_push) begin
			load.valid            = 1'b1;
			load.item.result_kind = trp_pkg::RES_STATUS;
			load.item.accepted    = !req.link_configured || !full;
		end
	end

	// Pointers and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			busy_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_next;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_next;
			end
			if (start) begin
				busy_q <= 1'b1;
			end else if (req_fire && is_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Drain sequencer and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			last_s1     <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_valid_s1 <= 1'b1;
				last_s1     <= issue_last;
				cnt_q       <= cnt_q + 1'b1;
			end else if (s1_move) begin
				rd_valid_s1 <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DRAIN;
						cnt_q   <= '0;
					end
				end
				ST_DRAIN: begin
					if (rd_en && issue_last) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (s1_move) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Ring is never written while a packet drains
	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_IDLE)
		else $error("ring written during packet drain");

	// Never read from an empty ring
	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_ptr_q != wr_ptr_q)
		else $error("ring read while empty");

	// Output register is loaded only when it has room
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load.valid |-> out_free)
		else $error("output register overwritten");

	// A started packet leaves the endpoint busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && state_q == ST_DRAIN)
		else $error("packet start did not set busy");

	// The read stage is empty whenever new items can be taken
	a_s1_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> state_q != ST_IDLE)
		else $error("read stage holds data while idle");

endmodule

// ----- rtl/tx_ring_packetizer.sv -----
// Top level of the transmit ring packetizer.
// Instantiates trp_ctrl, trp_ram and trp_out; depends on trp_pkg.
//
// Usage:
//   Request channel (req_valid / req_stall / req) carries push, kick and
//   transmit-complete items. Result channel (rsp_valid / rsp_stall / rsp)
//   returns one status item per push and one item per packet byte, the last
//   byte of a packet flagged by packet_last.
//   Pushes stream at one item per cycle while the receiver keeps up. The
//   status of a push is loaded into the output register at the accepting edge.
//   A kick or transmit complete that starts a packet drains up to PACKET_MAX
//   bytes at one byte per cycle while the receiver keeps up, set by the single
//   read port of the ring RAM. The controller enters its drain state, each
//   byte is read from the ring into the read stage and then enters the output
//   register, and the request channel stalls until the last byte has entered
//   the output register.
//   Reset clears both ring pointers and the busy flag; ring contents are not
//   cleared and need no clearing pass.
//   When the receiver stalls, the output register holds its item, the drain
//   pauses and the request channel stalls until the register frees up.
module tx_ring_packetizer #(
	parameter int FIFO_DEPTH = trp_pkg::FIFO_DEPTH_DEF,
	parameter int PACKET_MAX = trp_pkg::PACKET_MAX_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  trp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output trp_pkg::rsp_t rsp
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	trp_pkg::load_t   load;
	logic             out_free;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;
	logic [7:0]       wr_data;
	logic             rd_en;
	logic [PTR_W-1:0] rd_addr;
	logic [7:0]       rd_data;

	// Pointer and packet control
	trp_ctrl #(
		.FIFO_DEPTH(FIFO_DEPTH),
		.PACKET_MAX(PACKET_MAX)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.out_free (out_free),
		.load     (load),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	// Ring storage
	trp_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Result register
	trp_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.free     (out_free),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule
